>>> hdl/cbcs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbcs_pkg: shared types and constants of the circle / box collision step
// Item and result layouts, codes, configuration bundle and saturation helper.
// ----------------------------------------------------------------------------
package cbcs_pkg;

   localparam int MAX_BOXES   = 64;
   localparam int BOX_AW      = $clog2(MAX_BOXES);
   localparam int BOX_CW      = BOX_AW + 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_STEP   = 2'd2;

   localparam logic [1:0] KIND_CLEAR  = 2'd0;
   localparam logic [1:0] KIND_APPEND = 2'd1;
   localparam logic [1:0] KIND_STEP   = 2'd2;

   localparam logic [2:0] ST_FREE    = 3'd0;
   localparam logic [2:0] ST_HIT     = 3'd1;
   localparam logic [2:0] ST_REST    = 3'd2;
   localparam logic [2:0] ST_STORED  = 3'd3;
   localparam logic [2:0] ST_FULL    = 3'd4;
   localparam logic [2:0] ST_CLEARED = 3'd5;

   localparam logic [1:0] CSR_STEP_TIME     = 2'd0;
   localparam logic [1:0] CSR_GRAVITY_Y     = 2'd1;
   localparam logic [1:0] CSR_REST_LIMIT    = 2'd2;
   localparam logic [1:0] CSR_SLOW_SPEED_SQ = 2'd3;

   localparam logic [15:0] RST_STEP_TIME     = 16'd1092;
   localparam logic [31:0] RST_GRAVITY_Y     = 32'd655360;
   localparam logic [7:0]  RST_REST_LIMIT    = 8'd10;
   localparam logic [30:0] RST_SLOW_SPEED_SQ = 31'd1311;

   localparam logic [16:0] PUSH_Q16 = 17'd65602;
   localparam logic [16:0] ONE_Q16  = 17'd65536;

   typedef struct packed {
      logic [15:0]        step_time;
      logic signed [31:0] gravity_y;
      logic [7:0]         rest_limit;
      logic [30:0]        slow_speed_sq;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] lo_x;
      logic signed [31:0] lo_y;
      logic signed [31:0] hi_x;
      logic signed [31:0] hi_y;
   } box_type;

   typedef struct packed {
      logic [1:0]         kind;
      box_type            box;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic [30:0]        radius;
      logic [14:0]        elasticity;
      logic [7:0]         rest_frames;
   } item_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] new_pos_x;
      logic signed [31:0] new_pos_y;
      logic signed [31:0] new_vel_x;
      logic signed [31:0] new_vel_y;
      logic [7:0]         new_rest_frames;
   } result_type;

   function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
      if (v > 56'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -56'sd2147483648) begin
         return 32'sh80000000;
      end
      return $signed(v[31:0]);
   endfunction

endpackage
`default_nettype wire

>>> hdl/cbcs_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbcs_front: input stage
// Accepts request words, decodes the operation and hands items to the queue.
// ----------------------------------------------------------------------------
module cbcs_front
   import cbcs_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [311:0] req_tdata,
   input  wire logic [1:0]   req_tuser,
   input  wire logic         q_full,
   output logic              q_push,
   output item_type          q_item
);

   logic     stage_vld_ff, stage_vld_in;
   item_type stage_ff, stage_in;
   logic     take;

   assign req_tready = !stage_vld_ff || !q_full;
   assign take       = req_tvalid && req_tready;
   assign q_push     = stage_vld_ff && !q_full;
   assign q_item     = stage_ff;

   always_comb begin
      stage_in = stage_ff;
      case (req_tuser)
         OP_CLEAR:  stage_in.kind = KIND_CLEAR;
         OP_APPEND: stage_in.kind = KIND_APPEND;
         OP_STEP:   stage_in.kind = KIND_STEP;
         default:   stage_in.kind = KIND_STEP;
      endcase
      stage_in.box.lo_x     = $signed(req_tdata[31:0]);
      stage_in.box.lo_y     = $signed(req_tdata[63:32]);
      stage_in.box.hi_x     = $signed(req_tdata[95:64]);
      stage_in.box.hi_y     = $signed(req_tdata[127:96]);
      stage_in.pos_x        = $signed(req_tdata[159:128]);
      stage_in.pos_y        = $signed(req_tdata[191:160]);
      stage_in.vel_x        = $signed(req_tdata[223:192]);
      stage_in.vel_y        = $signed(req_tdata[255:224]);
      stage_in.radius       = req_tdata[286:256];
      stage_in.elasticity   = req_tdata[301:287];
      stage_in.rest_frames  = req_tdata[309:302];
      if (take) begin
         stage_vld_in = 1'b1;
      end else if (q_push) begin
         stage_vld_in = 1'b0;
      end else begin
         stage_vld_in = stage_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= 1'b0;
      end else begin
         stage_vld_ff <= stage_vld_in;
      end
      if (take) begin
         stage_ff <= stage_in;
      end
   end

endmodule
`default_nettype wire

>>> hdl/cbcs_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbcs_queue: short item queue
// Decouples the input stage from the step engine.
// ----------------------------------------------------------------------------
module cbcs_queue
   import cbcs_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_item,
   output logic          full,
   input  wire logic     pop,
   output logic          empty,
   output item_type      head
);

   item_type             slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]    cnt_ff;

   assign full  = (cnt_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

>>> hdl/cbcs_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbcs_back: step engine
// Owns the box table, runs the circle step sequence and holds the result.
// ----------------------------------------------------------------------------
module cbcs_back
   import cbcs_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cfg_type      cfg,
   input  wire logic         q_empty,
   input  wire item_type     q_head,
   output logic              q_pop,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output result_type        rsp_word
);

   localparam logic [4:0] S_IDLE = 5'd0,  S_V1 = 5'd1,  S_V2 = 5'd2,  S_V3 = 5'd3;
   localparam logic [4:0] S_V4   = 5'd4,  S_V5 = 5'd5,  S_CTR = 5'd6, S_RR = 5'd7;
   localparam logic [4:0] S_BRD  = 5'd8,  S_BCL = 5'd9, S_BS1 = 5'd10, S_BS2 = 5'd11;
   localparam logic [4:0] S_BS3  = 5'd12, S_HIT = 5'd13, S_R1 = 5'd14, S_R2 = 5'd15;
   localparam logic [4:0] S_R3   = 5'd16, S_R4 = 5'd17, S_R5 = 5'd18, S_R6 = 5'd19;
   localparam logic [4:0] S_R7   = 5'd20, S_R8 = 5'd21, S_SQ = 5'd22, S_DIV0 = 5'd23;
   localparam logic [4:0] S_DIV  = 5'd24, S_M0 = 5'd25, S_M1 = 5'd26, S_M2 = 5'd27;
   localparam logic [4:0] S_M3   = 5'd28, S_M4 = 5'd29, S_M5 = 5'd30, S_OUT = 5'd31;

   logic [4:0] state_ff, state_in;

   logic signed [31:0] px_ff, px_in, py_ff, py_in, vx_ff, vx_in, vy_ff, vy_in;
   logic signed [31:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [30:0]        r_ff, r_in;
   logic [14:0]        e_ff, e_in;
   logic [7:0]         rf_ff, rf_in;
   logic [2:0]         status_ff, status_in;
   logic signed [33:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [33:0] sx_ff, sx_in, sy_ff, sy_in;
   logic signed [33:0] bsx_ff, bsx_in, bsy_ff, bsy_in;
   logic signed [33:0] remf_ff, remf_in;
   logic signed [47:0] t_ff, t_in;
   logic [63:0]        rr_ff, rr_in, best_ff, best_in, acc_ff, acc_in;
   logic               hit_ff, hit_in, nrm_x_ff, nrm_x_in, nrm_neg_ff, nrm_neg_in;
   logic [BOX_CW-1:0]  idx_ff, idx_in, count_ff, count_in;
   logic [31:0]        rp_ff, rp_in, pen_ff, pen_in, dist_ff, dist_in;
   logic [63:0]        dist_sq_ff, dist_sq_in;
   logic [63:0]        sq_v_ff, sq_v_in, sq_r_ff, sq_r_in, sq_bit_ff, sq_bit_in;
   logic               sq_pass_ff, sq_pass_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic [47:0]        num_ff, num_in, q_ff, q_in;
   logic [31:0]        drem_ff, drem_in;
   logic               out_vld_ff, out_vld_in;
   result_type         out_ff, out_in;

   logic signed [33:0] ma_a, ma_b;
   logic signed [47:0] mb_a;
   logic signed [17:0] mb_b;
   logic signed [67:0] prod_a_ff;
   logic signed [65:0] prod_b_ff;
   logic signed [67:0] pa_r14, pa_r16;
   logic signed [53:0] pa_q14;
   logic signed [51:0] pa_q16;
   logic signed [65:0] pb_r16;
   logic signed [49:0] pb_q16;

   logic [127:0]       box_mem [MAX_BOXES];
   logic               wr_en;
   logic [BOX_AW-1:0]  wr_addr;
   box_type            wr_box;
   box_type            rd_box_ff;

   logic signed [33:0] bnx, bny;
   logic signed [34:0] bdx, bdy;
   logic [34:0]        bax, bay;
   logic               bskip;
   logic [63:0]        sq_t, sq_newr, sum_sq;
   logic               sq_ge;
   logic [32:0]        dv_trial;
   logic               dv_ge;
   logic [31:0]        q_cap;
   logic signed [17:0] dt_s;

   assign pa_r14 = prod_a_ff + 68'sd8192;
   assign pa_r16 = prod_a_ff + 68'sd32768;
   assign pa_q14 = $signed(pa_r14[67:14]);
   assign pa_q16 = $signed(pa_r16[67:16]);
   assign pb_r16 = prod_b_ff + 66'sd32768;
   assign pb_q16 = $signed(pb_r16[65:16]);
   assign sum_sq = acc_ff + prod_a_ff[63:0];
   assign dt_s   = $signed({2'b00, cfg.step_time});

   assign q_pop      = (state_ff == S_IDLE) && !q_empty;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_word   = out_ff;

   // clamp the centre to the box just read
   always_comb begin
      bnx = cx_ff;
      if (bnx < 34'(rd_box_ff.lo_x)) bnx = 34'(rd_box_ff.lo_x);
      if (bnx > 34'(rd_box_ff.hi_x)) bnx = 34'(rd_box_ff.hi_x);
      bny = cy_ff;
      if (bny < 34'(rd_box_ff.lo_y)) bny = 34'(rd_box_ff.lo_y);
      if (bny > 34'(rd_box_ff.hi_y)) bny = 34'(rd_box_ff.hi_y);
      bdx   = 35'(cx_ff) - 35'(bnx);
      bdy   = 35'(cy_ff) - 35'(bny);
      bax   = bdx[34] ? 35'(-bdx) : 35'(bdx);
      bay   = bdy[34] ? 35'(-bdy) : 35'(bdy);
      bskip = (bax > {4'b0, r_ff}) || (bay > {4'b0, r_ff});
   end

   always_comb begin
      sq_t     = sq_r_ff + sq_bit_ff;
      sq_ge    = sq_v_ff >= sq_t;
      sq_newr  = sq_ge ? ((sq_r_ff >> 1) + sq_bit_ff) : (sq_r_ff >> 1);
      dv_trial = {drem_ff, num_ff[47]};
      dv_ge    = dv_trial >= {1'b0, dist_ff};
      q_cap    = (q_ff > 48'h0000_8000_0000) ? 32'h8000_0000 : q_ff[31:0];
   end

   always_comb begin
      state_in   = state_ff;
      px_in = px_ff;  py_in = py_ff;  vx_in = vx_ff;  vy_in = vy_ff;
      dx_in = dx_ff;  dy_in = dy_ff;  r_in = r_ff;    e_in = e_ff;
      rf_in = rf_ff;  status_in = status_ff;
      cx_in = cx_ff;  cy_in = cy_ff;  sx_in = sx_ff;  sy_in = sy_ff;
      bsx_in = bsx_ff; bsy_in = bsy_ff; remf_in = remf_ff; t_in = t_ff;
      rr_in = rr_ff;  best_in = best_ff; acc_in = acc_ff;
      hit_in = hit_ff; nrm_x_in = nrm_x_ff; nrm_neg_in = nrm_neg_ff;
      idx_in = idx_ff; count_in = count_ff; rp_in = rp_ff;
      pen_in = pen_ff; dist_in = dist_ff; dist_sq_in = dist_sq_ff;
      sq_v_in = sq_v_ff; sq_r_in = sq_r_ff; sq_bit_in = sq_bit_ff;
      sq_pass_in = sq_pass_ff; cnt_in = cnt_ff;
      num_in = num_ff; q_in = q_ff; drem_in = drem_ff;
      out_in = out_ff;
      out_vld_in = out_vld_ff && !rsp_tready;
      ma_a = '0; ma_b = '0; mb_a = '0; mb_b = '0;
      wr_en = 1'b0;
      wr_addr = count_ff[BOX_AW-1:0];
      wr_box  = q_head.box;

      case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               px_in = '0; py_in = '0; vx_in = '0; vy_in = '0; rf_in = '0;
               case (q_head.kind)
                  KIND_CLEAR: begin
                     count_in  = '0;
                     status_in = ST_CLEARED;
                     state_in  = S_OUT;
                  end
                  KIND_APPEND: begin
                     if (count_ff < BOX_CW'(MAX_BOXES)) begin
                        wr_en     = 1'b1;
                        count_in  = count_ff + 1'b1;
                        status_in = ST_STORED;
                     end else begin
                        status_in = ST_FULL;
                     end
                     state_in = S_OUT;
                  end
                  default: begin
                     px_in = q_head.pos_x;  py_in = q_head.pos_y;
                     vx_in = q_head.vel_x;  vy_in = q_head.vel_y;
                     r_in  = q_head.radius; e_in  = q_head.elasticity;
                     rf_in = q_head.rest_frames;
                     if (q_head.rest_frames >= cfg.rest_limit) begin
                        status_in = ST_REST;
                        state_in  = S_OUT;
                     end else begin
                        state_in = S_V1;
                     end
                  end
               endcase
            end
         end
         S_V1: begin
            ma_a = 34'(vx_ff); ma_b = 34'(vx_ff);
            mb_a = 48'(cfg.gravity_y); mb_b = dt_s;
            state_in = S_V2;
         end
         S_V2: begin
            acc_in = prod_a_ff[63:0];
            ma_a = 34'(vy_ff); ma_b = 34'(vy_ff);
            vy_in = sat32(56'(vy_ff) + 56'(pb_q16));
            state_in = S_V3;
         end
         S_V3: begin
            if (sum_sq < {17'b0, cfg.slow_speed_sq, 16'b0} && rf_ff != 8'hff) begin
               rf_in = rf_ff + 1'b1;
            end
            mb_a = 48'(vx_ff); mb_b = dt_s;
            state_in = S_V4;
         end
         S_V4: begin
            dx_in = $signed(pb_q16[31:0]);
            px_in = sat32(56'(px_ff) + 56'(pb_q16));
            mb_a = 48'(vy_ff); mb_b = dt_s;
            state_in = S_V5;
         end
         S_V5: begin
            dy_in = $signed(pb_q16[31:0]);
            py_in = sat32(56'(py_ff) + 56'(pb_q16));
            state_in = S_CTR;
         end
         S_CTR: begin
            cx_in = 34'(px_ff) + $signed({3'b0, r_ff});
            cy_in = 34'(py_ff) + $signed({3'b0, r_ff});
            ma_a = $signed({3'b0, r_ff}); ma_b = $signed({3'b0, r_ff});
            state_in = S_RR;
         end
         S_RR: begin
            rr_in  = prod_a_ff[63:0];
            idx_in = '0;
            hit_in = 1'b0;
            state_in = S_BRD;
         end
         S_BRD: begin
            state_in = (idx_ff < count_ff) ? S_BCL : S_HIT;
         end
         S_BCL: begin
            sx_in = bdx[33:0];
            sy_in = bdy[33:0];
            if (bskip) begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_BRD;
            end else begin
               state_in = S_BS1;
            end
         end
         S_BS1: begin
            ma_a = sx_ff; ma_b = sx_ff;
            state_in = S_BS2;
         end
         S_BS2: begin
            acc_in = prod_a_ff[63:0];
            ma_a = sy_ff; ma_b = sy_ff;
            state_in = S_BS3;
         end
         S_BS3: begin
            if (sum_sq < rr_ff && (!hit_ff || sum_sq < best_ff)) begin
               hit_in  = 1'b1;
               best_in = sum_sq;
               bsx_in  = sx_ff;
               bsy_in  = sy_ff;
            end
            idx_in   = idx_ff + 1'b1;
            state_in = S_BRD;
         end
         S_HIT: begin
            if (!hit_ff) begin
               status_in = ST_FREE;
               state_in  = S_OUT;
            end else begin
               sx_in = bsx_ff;
               sy_in = bsy_ff;
               if ((bsx_ff[33] ? -bsx_ff : bsx_ff) > (bsy_ff[33] ? -bsy_ff : bsy_ff)) begin
                  nrm_x_in   = 1'b1;
                  nrm_neg_in = bsx_ff[33];
               end else begin
                  nrm_x_in   = 1'b0;
                  nrm_neg_in = bsy_ff[33];
               end
               state_in = S_R1;
            end
         end
         S_R1: begin
            ma_a = nrm_x_ff ? -34'(vx_ff) : 34'(vx_ff);
            ma_b = $signed({19'b0, e_ff});
            mb_a = $signed({17'b0, r_ff}); mb_b = $signed({1'b0, PUSH_Q16});
            state_in = S_R2;
         end
         S_R2: begin
            vx_in = sat32(56'(pa_q14));
            rp_in = pb_q16[31:0];
            ma_a = nrm_x_ff ? 34'(vy_ff) : -34'(vy_ff);
            ma_b = $signed({19'b0, e_ff});
            state_in = S_R3;
         end
         S_R3: begin
            vy_in = sat32(56'(pa_q14));
            if (nrm_x_ff) begin
               sx_in = nrm_neg_ff ? sx_ff + $signed({2'b0, rp_ff})
                                  : sx_ff - $signed({2'b0, rp_ff});
            end else begin
               sy_in = nrm_neg_ff ? sy_ff + $signed({2'b0, rp_ff})
                                  : sy_ff - $signed({2'b0, rp_ff});
            end
            state_in = S_R4;
         end
         S_R4: begin
            px_in = sat32(56'(px_ff) - 56'(sx_ff));
            py_in = sat32(56'(py_ff) - 56'(sy_ff));
            ma_a = sx_ff; ma_b = sx_ff;
            state_in = S_R5;
         end
         S_R5: begin
            acc_in = prod_a_ff[63:0];
            ma_a = sy_ff; ma_b = sy_ff;
            state_in = S_R6;
         end
         S_R6: begin
            sq_v_in = sum_sq;
            ma_a = 34'(dx_ff); ma_b = 34'(dx_ff);
            state_in = S_R7;
         end
         S_R7: begin
            acc_in = prod_a_ff[63:0];
            ma_a = 34'(dy_ff); ma_b = 34'(dy_ff);
            state_in = S_R8;
         end
         S_R8: begin
            dist_sq_in = sum_sq;
            sq_r_in    = '0;
            sq_bit_in  = 64'h4000_0000_0000_0000;
            sq_pass_in = 1'b0;
            cnt_in     = 6'd31;
            state_in   = S_SQ;
         end
         S_SQ: begin
            if (sq_ge) sq_v_in = sq_v_ff - sq_t;
            sq_r_in   = sq_newr;
            sq_bit_in = sq_bit_ff >> 2;
            cnt_in    = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               if (!sq_pass_ff) begin
                  pen_in     = sq_newr[31:0];
                  sq_v_in    = dist_sq_ff;
                  sq_r_in    = '0;
                  sq_bit_in  = 64'h4000_0000_0000_0000;
                  sq_pass_in = 1'b1;
                  cnt_in     = 6'd31;
               end else begin
                  dist_in  = sq_newr[31:0];
                  state_in = S_DIV0;
               end
            end
         end
         S_DIV0: begin
            if (dist_ff == '0) begin
               status_in = ST_HIT;
               state_in  = S_OUT;
            end else begin
               num_in   = {pen_ff, 16'b0};
               drem_in  = '0;
               q_in     = '0;
               cnt_in   = 6'd47;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            drem_in = dv_ge ? 32'(dv_trial - {1'b0, dist_ff}) : dv_trial[31:0];
            q_in    = {q_ff[46:0], dv_ge};
            num_in  = {num_ff[46:0], 1'b0};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) state_in = S_M0;
         end
         S_M0: begin
            remf_in  = $signed({17'b0, ONE_Q16}) - $signed({2'b0, q_cap});
            state_in = S_M1;
         end
         S_M1: begin
            ma_a = 34'(vx_ff); ma_b = remf_ff;
            state_in = S_M2;
         end
         S_M2: begin
            mb_a = pa_q16[47:0]; mb_b = dt_s;
            ma_a = 34'(vy_ff); ma_b = remf_ff;
            state_in = S_M3;
         end
         S_M3: begin
            px_in = sat32(56'(px_ff) + 56'(pb_q16));
            t_in  = pa_q16[47:0];
            state_in = S_M4;
         end
         S_M4: begin
            mb_a = t_ff; mb_b = dt_s;
            state_in = S_M5;
         end
         S_M5: begin
            py_in = sat32(56'(py_ff) + 56'(pb_q16));
            status_in = ST_HIT;
            state_in  = S_OUT;
         end
         S_OUT: begin
            if (!out_vld_ff || rsp_tready) begin
               out_in.status          = status_ff;
               out_in.new_pos_x       = px_ff;
               out_in.new_pos_y       = py_ff;
               out_in.new_vel_x       = vx_ff;
               out_in.new_vel_y       = vy_ff;
               out_in.new_rest_frames = rf_ff;
               out_vld_in = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         out_vld_ff <= out_vld_in;
      end
      px_ff <= px_in;  py_ff <= py_in;  vx_ff <= vx_in;  vy_ff <= vy_in;
      dx_ff <= dx_in;  dy_ff <= dy_in;  r_ff <= r_in;    e_ff <= e_in;
      rf_ff <= rf_in;  status_ff <= status_in;
      cx_ff <= cx_in;  cy_ff <= cy_in;  sx_ff <= sx_in;  sy_ff <= sy_in;
      bsx_ff <= bsx_in; bsy_ff <= bsy_in; remf_ff <= remf_in; t_ff <= t_in;
      rr_ff <= rr_in;  best_ff <= best_in; acc_ff <= acc_in;
      hit_ff <= hit_in; nrm_x_ff <= nrm_x_in; nrm_neg_ff <= nrm_neg_in;
      idx_ff <= idx_in; rp_ff <= rp_in;
      pen_ff <= pen_in; dist_ff <= dist_in; dist_sq_ff <= dist_sq_in;
      sq_v_ff <= sq_v_in; sq_r_ff <= sq_r_in; sq_bit_ff <= sq_bit_in;
      sq_pass_ff <= sq_pass_in; cnt_ff <= cnt_in;
      num_ff <= num_in; q_ff <= q_in; drem_ff <= drem_in;
      out_ff <= out_in;
      prod_a_ff <= 68'(ma_a) * 68'(ma_b);
      prod_b_ff <= 66'(mb_a) * 66'(mb_b);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         box_mem[wr_addr] <= wr_box;
      end
      rd_box_ff <= box_mem[idx_ff[BOX_AW-1:0]];
   end

endmodule
`default_nettype wire

>>> hdl/circle_box_collision_step_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// circle_box_collision_step_core: circle versus static box step
// Keeps a table of up to 64 boxes and advances one circle per step request.
//
// Request channel (req_): tuser carries the operation (clear table, append
// box, step circle); tdata carries the box corners and the circle state.
// Response channel (rsp_): one word per request; tuser carries the status,
// tdata the updated circle position, velocity and rest count.
// CSR port: single-cycle writes of step time, gravity, rest limit and slow
// speed limit; write only while the block is idle.
// Sequence: clear, append and a resting step go straight to the response.
// A step walks the table, reading every stored box and testing further each
// box within the circle bounds. A hit adds two square roots and a divide;
// the divide is skipped when the step did not move.
// Throughput: one item at a time in the engine; a two-entry queue and an
// input stage keep taking requests while the engine works, until both fill.
// Reset empties the box table count, the queue and the response register.
// A stalled response holds its word; the engine waits before the next one.
// ----------------------------------------------------------------------------
module circle_box_collision_step_core
   import cbcs_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // box_lo_x, box_lo_y, box_hi_x, box_hi_y, pos_x, pos_y, vel_x, vel_y,
   // radius, elasticity, rest_frames, zero fill
   input  wire logic [311:0] req_tdata,
   // op
   input  wire logic [1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // new_pos_x, new_pos_y, new_vel_x, new_vel_y, new_rest_frames
   output logic [135:0]      rsp_tdata,
   // status
   output logic [2:0]        rsp_tuser,
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_addr,
   input  wire logic [31:0]  csr_wdata
);

   cfg_type    cfg_ff;
   logic       q_full, q_push, q_pop, q_empty;
   item_type   q_item, q_head;
   result_type rsp_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_time     <= RST_STEP_TIME;
         cfg_ff.gravity_y     <= $signed(RST_GRAVITY_Y);
         cfg_ff.rest_limit    <= RST_REST_LIMIT;
         cfg_ff.slow_speed_sq <= RST_SLOW_SPEED_SQ;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_STEP_TIME:     cfg_ff.step_time     <= csr_wdata[15:0];
            CSR_GRAVITY_Y:     cfg_ff.gravity_y     <= $signed(csr_wdata);
            CSR_REST_LIMIT:    cfg_ff.rest_limit    <= csr_wdata[7:0];
            CSR_SLOW_SPEED_SQ: cfg_ff.slow_speed_sq <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   cbcs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (q_item)
   );

   cbcs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   cbcs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_word   (rsp_word)
   );

   assign rsp_tuser = rsp_word.status;
   assign rsp_tdata = {rsp_word.new_rest_frames, rsp_word.new_vel_y, rsp_word.new_vel_x,
                       rsp_word.new_pos_y, rsp_word.new_pos_x};

endmodule
`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for circle_box_collision_step_core
// Streams clear, append and step requests through the core under several
// register settings and random backpressure, predicts every response word
// in Q16.16 and compares it field by field with what the core returns.
// ----------------------------------------------------------------------------
module tb;
   import cbcs_pkg::*;

   localparam longint UNIT      = 65536;
   localparam longint CYC_LIMIT = 4000000;
   localparam logic [1:0] OP_STEP_ALT = 2'd3;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [311:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [135:0] rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         csr_we = 1'b0;
   logic [1:0]   csr_addr = '0;
   logic [31:0]  csr_wdata = '0;

   circle_box_collision_step_core dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   box_type    boxes [MAX_BOXES];
   int         box_cnt;
   longint     cur_step_time, cur_gravity, cur_rest_limit, cur_slow_sq;

   item_type   pending [$];
   result_type expected [$];
   item_type   on_bus;
   int         send_idle = 0;
   int         recv_idle = 0;
   bit         hold_armed = 0;
   bit         hold_done = 0;
   int         hold_left = 0;
   int         fails = 0;
   longint     cycles = 0;
   int         n_words = 0, n_hit = 0, n_rest = 0, n_full = 0, n_free = 0;

   function automatic longint sat_q(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint round_shr(input longint v, input int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint unsigned abs_u(input longint v);
      return v < 0 ? longint'(-v) : v;
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic result_type predict_word(input item_type it);
      result_type res;
      longint px, py, vx, vy, dx, dy, cx, cy, r, e, dt, hx, hy;
      longint sx, sy, nx, ny, dir_x, dir_y, rp, pen_x, pen_y, rem;
      longint unsigned rf, sp2, d2, best, pen, travel, q;
      bit hit;
      res = '0;
      hx = 0; hy = 0; best = 0; hit = 0;
      if (it.kind == OP_CLEAR) begin
         box_cnt = 0;
         res.status = ST_CLEARED;
         return res;
      end
      if (it.kind == OP_APPEND) begin
         if (box_cnt < MAX_BOXES) begin
            boxes[box_cnt] = it.box;
            box_cnt++;
            res.status = ST_STORED;
         end else begin
            res.status = ST_FULL;
         end
         return res;
      end
      px = longint'(it.pos_x); py = longint'(it.pos_y);
      vx = longint'(it.vel_x); vy = longint'(it.vel_y);
      r = longint'(it.radius); e = longint'(it.elasticity);
      rf = it.rest_frames; dt = cur_step_time;
      if (rf >= cur_rest_limit) begin
         res.status = ST_REST;
      end else begin
         sp2 = abs_u(vx) * abs_u(vx) + abs_u(vy) * abs_u(vy);
         if (sp2 < (longint'(cur_slow_sq) << 16) && rf < 255) rf++;
         vy = sat_q(vy + round_shr(cur_gravity * dt, 16));
         dx = round_shr(vx * dt, 16);
         dy = round_shr(vy * dt, 16);
         px = sat_q(px + dx);
         py = sat_q(py + dy);
         cx = px + r;
         cy = py + r;
         for (int b = 0; b < box_cnt; b++) begin
            nx = cx; ny = cy;
            if (nx < longint'(boxes[b].lo_x)) nx = boxes[b].lo_x;
            if (nx > longint'(boxes[b].hi_x)) nx = boxes[b].hi_x;
            if (ny < longint'(boxes[b].lo_y)) ny = boxes[b].lo_y;
            if (ny > longint'(boxes[b].hi_y)) ny = boxes[b].hi_y;
            sx = cx - nx; sy = cy - ny;
            if (abs_u(sx) > r || abs_u(sy) > r) continue;
            d2 = abs_u(sx) * abs_u(sx) + abs_u(sy) * abs_u(sy);
            if (d2 < longint'(r * r) && (!hit || d2 < best)) begin
               hit = 1; best = d2; hx = nx; hy = ny;
            end
         end
         res.status = ST_FREE;
         if (hit) begin
            sx = cx - hx; sy = cy - hy; dir_x = 0; dir_y = 0;
            if (abs_u(sx) > abs_u(sy)) dir_x = sx < 0 ? -1 : 1;
            else dir_y = sy < 0 ? -1 : 1;
            vx = sat_q(round_shr((dir_x != 0 ? -vx : vx) * e, 14));
            vy = sat_q(round_shr((dir_y != 0 ? -vy : vy) * e, 14));
            rp = round_shr(r * longint'(PUSH_Q16), 16);
            pen_x = sx - dir_x * rp;
            pen_y = sy - dir_y * rp;
            px = sat_q(px - pen_x);
            py = sat_q(py - pen_y);
            pen = int_sqrt(abs_u(pen_x) * abs_u(pen_x) + abs_u(pen_y) * abs_u(pen_y));
            travel = int_sqrt(abs_u(dx) * abs_u(dx) + abs_u(dy) * abs_u(dy));
            if (travel != 0) begin
               q = (pen << 16) / travel;
               if (q > (64'd1 << 31)) q = 64'd1 << 31;
               rem = longint'(ONE_Q16) - longint'(q);
               px = sat_q(px + round_shr(round_shr(vx * rem, 16) * dt, 16));
               py = sat_q(py + round_shr(round_shr(vy * rem, 16) * dt, 16));
            end
            res.status = ST_HIT;
         end
      end
      res.new_pos_x = px[31:0];
      res.new_pos_y = py[31:0];
      res.new_vel_x = vx[31:0];
      res.new_vel_y = vy[31:0];
      res.new_rest_frames = rf[7:0];
      return res;
   endfunction

   function automatic logic [311:0] pack_word(input item_type it);
      return {2'b0, it.rest_frames, it.elasticity, it.radius, it.vel_y, it.vel_x,
              it.pos_y, it.pos_x, it.box.hi_y, it.box.hi_x, it.box.lo_y, it.box.lo_x};
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) expected.push_back(predict_word(on_bus));
         if (!req_tvalid || req_tready) begin
            if (pending.size() > 0 && $urandom_range(99) >= send_idle) begin
               on_bus = pending.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= pack_word(on_bus);
               req_tuser <= on_bus.kind;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver backpressure, with one long hold-off when armed
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_armed && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_left <= 3000;
         hold_done <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   task automatic report(input string fld, input longint got, input longint want);
      $display("mismatch word %0d %s: got %h expected %h", n_words, fld, got, want);
      fails++;
   endtask

   // monitor
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected.size() == 0) begin
            report("unexpected word status", rsp_tuser, 0);
         end else begin
            want = expected.pop_front();
            if (rsp_tuser != want.status) report("status", rsp_tuser, want.status);
            if (rsp_tdata[31:0] != want.new_pos_x)
               report("new_pos_x", rsp_tdata[31:0], want.new_pos_x);
            if (rsp_tdata[63:32] != want.new_pos_y)
               report("new_pos_y", rsp_tdata[63:32], want.new_pos_y);
            if (rsp_tdata[95:64] != want.new_vel_x)
               report("new_vel_x", rsp_tdata[95:64], want.new_vel_x);
            if (rsp_tdata[127:96] != want.new_vel_y)
               report("new_vel_y", rsp_tdata[127:96], want.new_vel_y);
            if (rsp_tdata[135:128] != want.new_rest_frames)
               report("new_rest_frames", rsp_tdata[135:128], want.new_rest_frames);
            case (want.status)
               ST_HIT: n_hit++;
               ST_REST: n_rest++;
               ST_FULL: n_full++;
               ST_FREE: n_free++;
               default: ;
            endcase
         end
         n_words++;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYC_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycles, expected.size());
         $display("tb failed");
         $finish;
      end
   end

   function automatic logic signed [31:0] scene(input int span);
      return 32'((int'($urandom_range(2 * span)) - span) * UNIT + $urandom_range(65535));
   endfunction

   function automatic item_type make_item(input logic [1:0] op, input bit wild);
      item_type it;
      int w, h;
      it = '0;
      it.kind = op;
      if (wild) begin
         it.box = {$urandom, $urandom, $urandom, $urandom};
         it.pos_x = $urandom; it.pos_y = $urandom;
         it.vel_x = $urandom; it.vel_y = $urandom;
         it.radius = 31'($urandom); it.elasticity = 15'($urandom);
         it.rest_frames = 8'($urandom);
      end else begin
         w = $urandom_range(1, 32); h = $urandom_range(1, 32);
         it.box.lo_x = scene(48); it.box.lo_y = scene(48);
         it.box.hi_x = 32'(it.box.lo_x + w * UNIT);
         it.box.hi_y = 32'(it.box.lo_y + h * UNIT);
         it.pos_x = scene(64); it.pos_y = scene(64);
         it.vel_x = scene(40); it.vel_y = scene(40);
         if ($urandom_range(3) == 0) it.vel_x = $urandom_range(300) - 150;
         it.radius = 31'($urandom_range(32768, 16 * UNIT));
         it.elasticity = 15'($urandom_range(32767));
         it.rest_frames = ($urandom_range(9) == 0) ? 8'd255 : 8'($urandom_range(12));
      end
      return it;
   endfunction

   function automatic logic [1:0] pick_op();
      int p;
      p = $urandom_range(99);
      if (p < 5) return OP_CLEAR;
      if (p < 25) return OP_APPEND;
      if (p < 95) return OP_STEP;
      return OP_STEP_ALT;
   endfunction

   task automatic queue_random(input int count);
      repeat (count) pending.push_back(make_item(pick_op(), $urandom_range(9) == 0));
   endtask

   task automatic settle();
      @(negedge clock);
      while (pending.size() > 0 || req_tvalid || expected.size() > 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic set_regs(input logic [15:0] st, input logic [31:0] gy,
                           input logic [7:0] rl, input logic [30:0] ss);
      @(posedge clock);
      csr_we <= 1'b1; csr_addr <= CSR_STEP_TIME; csr_wdata <= {16'b0, st};
      @(posedge clock);
      csr_addr <= CSR_GRAVITY_Y; csr_wdata <= gy;
      @(posedge clock);
      csr_addr <= CSR_REST_LIMIT; csr_wdata <= {24'b0, rl};
      @(posedge clock);
      csr_addr <= CSR_SLOW_SPEED_SQ; csr_wdata <= {1'b0, ss};
      @(posedge clock);
      csr_we <= 1'b0;
      cur_step_time = st; cur_gravity = longint'($signed(gy));
      cur_rest_limit = rl; cur_slow_sq = ss;
   endtask

   task automatic set_idle(input int snd, input int rcv);
      @(posedge clock);
      send_idle <= snd;
      recv_idle <= rcv;
   endtask

   initial begin
      item_type it;
      box_cnt = 0;
      cur_step_time = RST_STEP_TIME;
      cur_gravity = longint'($signed(RST_GRAVITY_Y));
      cur_rest_limit = RST_REST_LIMIT;
      cur_slow_sq = RST_SLOW_SPEED_SQ;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      set_idle(28, 53);

      // directed: table setup, extremes, resting, slow, zero radius, op three
      pending.push_back(make_item(OP_CLEAR, 0));
      it = make_item(OP_APPEND, 0);
      it.box = {32'sd655360, 32'sd655360, -32'sd655360, -32'sd655360};
      pending.push_back(it);
      it.box = {-32'sd655360, -32'sd655360, 32'sd655360, 32'sd655360};
      pending.push_back(it);
      it.box = {32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff};
      it.box = {it.box.hi_y, it.box.hi_x, it.box.lo_y, it.box.lo_x};
      pending.push_back(it);
      it = make_item(OP_STEP, 0);
      it.pos_x = -32'sd65536; it.pos_y = -32'sd1310720; it.vel_x = 32'sd3276800;
      it.vel_y = 32'sd6553600; it.radius = 31'd327680; it.elasticity = 15'd16384;
      it.rest_frames = 8'd0;
      pending.push_back(it);
      it.kind = OP_STEP_ALT;
      pending.push_back(it);
      it.kind = OP_STEP; it.radius = '0;
      pending.push_back(it);
      it.radius = 31'h7fffffff; it.elasticity = 15'h7fff;
      pending.push_back(it);
      it.pos_x = 32'sh7fffffff; it.pos_y = 32'sh7fffffff;
      it.vel_x = 32'sh7fffffff; it.vel_y = 32'sh7fffffff;
      pending.push_back(it);
      it.pos_x = 32'sh80000000; it.pos_y = 32'sh80000000;
      it.vel_x = 32'sh80000000; it.vel_y = 32'sh80000000; it.radius = 31'd65536;
      pending.push_back(it);
      it.rest_frames = 8'd255;
      pending.push_back(it);
      it.rest_frames = 8'd10;
      pending.push_back(it);
      it.rest_frames = 8'd9; it.vel_x = '0; it.vel_y = '0;
      pending.push_back(it);
      it = make_item(OP_APPEND, 1);
      pending.push_back(it);
      pending.push_back(make_item(OP_STEP, 1));
      pending.push_back(make_item(OP_CLEAR, 1));
      pending.push_back(make_item(OP_STEP, 0));
      queue_random(300);
      settle();

      set_regs(16'hffff, 32'h80000000, 8'd255, 31'h7fffffff);
      set_idle(53, 28);
      queue_random(300);
      settle();

      set_regs(16'h0000, 32'h7fffffff, 8'd0, 31'h0);
      queue_random(60);
      set_idle(53, 28);
      settle();
      set_regs(16'h0000, 32'h0000_0000, 8'd200, 31'h0);
      queue_random(40);
      settle();

      set_regs(16'd2000, -32'sd1310720, 8'd5, 31'd65536);
      set_idle(0, 0);
      hold_armed <= 1'b1;
      // fill the table past its limit, then step against a full table
      pending.push_back(make_item(OP_CLEAR, 0));
      repeat (MAX_BOXES + 2) pending.push_back(make_item(OP_APPEND, 0));
      repeat (10) pending.push_back(make_item(OP_STEP, 0));
      pending.push_back(make_item(OP_CLEAR, 0));
      queue_random(350);
      settle();

      $display("covered %0d words: %0d free, %0d collisions, %0d resting, %0d table full",
               n_words, n_free, n_hit, n_rest, n_full);
      $display("register settings: reset, both extremes and mid values; %0d mismatches", fails);
      if (fails == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
